// ----- sv/tvs_pkg.sv -----
package tvs_pkg;

    localparam int PEDAL_W     = 10;
    localparam int STEER_W     = 16;
    localparam int P_W         = 8;
    localparam int K_W         = 11;
    localparam int MAG_W       = 15;
    localparam int T_W         = 25;
    localparam int Y_W         = 20;
    localparam int E_W         = 17;
    localparam int TQ_W        = 8;
    localparam int DZ_W        = 7;
    localparam int CFG_IDX_W   = 8;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_VEC_ENABLE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE   = 8'd1;

    localparam logic [DZ_W-1:0] DEADZONE_RESET = 7'd2;

    // floor(x/6) = (x * 10923) >> 16 for x < 1024
    localparam logic [13:0] DIV6_RECIP  = 14'd10923;
    // log2(e) in Q16
    localparam logic [16:0] LOG2E_Q16   = 17'd94548;
    // floor(x/25) = (x * ceil(2^30/25)) >> 30 for x < 2^30
    localparam logic [25:0] DIV25_RECIP = 26'd42949673;

    localparam logic signed [STEER_W-1:0] STEER_HI = 16'sd16384;
    localparam logic signed [STEER_W-1:0] STEER_LO = -16'sd16384;

    localparam logic [17:0]     TWO_Q16     = 18'd131072;
    localparam logic [TQ_W-1:0] OUTSIDE_CAP = 8'd100;

    typedef enum logic [1:0] {
        MODE_ZERO,
        MODE_PASS,
        MODE_VEC
    } t_mode;

    typedef struct packed {
        logic [P_W-1:0] p;
        t_mode          mode;
        logic           right_turn;
    } t_ctl;

endpackage

// ----- sv/tvs_prep.sv -----
module tvs_prep (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_vld,
    output logic                                o_rdy,
    input  logic [tvs_pkg::PEDAL_W-1:0]         i_pedal,
    input  logic signed [tvs_pkg::STEER_W-1:0]  i_steer,
    input  logic                                i_brake,
    input  logic                                i_vec_en,
    input  logic [tvs_pkg::DZ_W-1:0]            i_dz,
    output logic                                o_vld,
    input  logic                                i_rdy,
    output logic [tvs_pkg::K_W-1:0]             o_k100,
    output logic [tvs_pkg::MAG_W-1:0]           o_mag,
    output tvs_pkg::t_ctl                       o_ctl
);
    import tvs_pkg::*;

    logic                r_vld1;
    logic [23:0]         r_prod;
    logic [MAG_W-1:0]    r_mag1;
    logic                r_pass;
    logic                r_right;

    logic                r_vld2;
    logic [K_W-1:0]      r_k100;
    logic [MAG_W-1:0]    r_mag2;
    t_ctl                r_ctl;

    logic                w_adv1;
    logic                w_adv2;
    logic [23:0]         n_prod;
    logic [STEER_W-1:0]  n_abs;
    logic                n_pass;
    logic                n_right;
    logic [P_W-1:0]      w_p;
    logic [K_W-1:0]      n_k100;
    t_ctl                n_ctl;

    assign w_adv2 = !r_vld2 || i_rdy;
    assign w_adv1 = !r_vld1 || w_adv2;
    assign o_rdy  = w_adv1;

    always_comb begin
        n_prod  = 24'(i_pedal) * 24'(DIV6_RECIP);
        n_abs   = i_steer[STEER_W-1] ? STEER_W'(-i_steer) : STEER_W'(i_steer);
        n_pass  = (i_steer > STEER_HI) || (i_steer < STEER_LO) || i_brake ||
                  !i_vec_en || (i_steer == '0);
        n_right = !i_steer[STEER_W-1] && (i_steer != '0);
    end

    always_comb begin
        w_p = r_prod[23:16];
        if (w_p == '0) begin
            n_k100 = '0;
        end else if (w_p <= 8'd10) begin
            n_k100 = K_W'(w_p) * 11'd108;
        end else if (w_p <= 8'd50) begin
            n_k100 = 11'd1080;
        end else if (w_p <= 8'd70) begin
            n_k100 = 11'd1080 - K_W'(w_p - 8'd50) * 11'd54;
        end else begin
            n_k100 = '0;
        end
        n_ctl.p          = w_p;
        n_ctl.right_turn = r_right;
        if (w_p < {1'b0, i_dz}) begin
            n_ctl.mode = MODE_ZERO;
        end else if (r_pass) begin
            n_ctl.mode = MODE_PASS;
        end else begin
            n_ctl.mode = MODE_VEC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_vld1 <= i_vld;
            end
            if (w_adv2) begin
                r_vld2 <= r_vld1;
            end
        end
        if (w_adv1) begin
            r_prod  <= n_prod;
            r_mag1  <= n_abs[MAG_W-1:0];
            r_pass  <= n_pass;
            r_right <= n_right;
        end
        if (w_adv2) begin
            r_k100 <= n_k100;
            r_mag2 <= r_mag1;
            r_ctl  <= n_ctl;
        end
    end

    assign o_vld  = r_vld2;
    assign o_k100 = r_k100;
    assign o_mag  = r_mag2;
    assign o_ctl  = r_ctl;

endmodule

// ----- sv/tvs_expo.sv -----
module tvs_expo (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    output logic                        o_rdy,
    input  logic [tvs_pkg::K_W-1:0]     i_k100,
    input  logic [tvs_pkg::MAG_W-1:0]   i_mag,
    input  tvs_pkg::t_ctl               i_ctl,
    output logic                        o_vld,
    input  logic                        i_rdy,
    output logic [tvs_pkg::E_W-1:0]     o_e,
    output tvs_pkg::t_ctl               o_ctl
);
    import tvs_pkg::*;

    localparam int NSTG = 4;

    logic [NSTG-1:0] r_vld;
    t_ctl            r_ctl [NSTG];
    logic [NSTG-1:0] w_adv;

    logic [T_W-1:0]  r_t;
    logic [T_W-1:0]  r_qh;
    logic [Y_W-1:0]  r_y;
    logic [E_W-1:0]  r_e;

    logic [40:0]     n_q;
    logic [50:0]     n_ym;
    logic [4:0]      n_sh;
    logic [17:0]     n_e;

    always_comb begin
        w_adv[NSTG-1] = !r_vld[NSTG-1] || i_rdy;
        for (int i = NSTG - 2; i >= 0; i--) begin
            w_adv[i] = !r_vld[i] || w_adv[i+1];
        end
    end
    assign o_rdy = w_adv[0];

    // t * log2(e), then / 2^16, then / 25 by reciprocal
    always_comb begin
        n_q  = 41'(r_t) * 41'(LOG2E_Q16);
        n_ym = 51'(r_qh) * 51'(DIV25_RECIP);
        n_sh = {1'b0, r_y[Y_W-1:16]} + 5'd1;
        n_e  = (TWO_Q16 - {2'b00, r_y[15:0]}) >> n_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_vld;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (w_adv[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
        if (w_adv[0]) begin
            r_ctl[0] <= i_ctl;
            r_t      <= T_W'(i_mag) * T_W'(i_k100);
        end
        for (int i = 1; i < NSTG; i++) begin
            if (w_adv[i]) begin
                r_ctl[i] <= r_ctl[i-1];
            end
        end
        if (w_adv[1]) begin
            r_qh <= n_q[40:16];
        end
        if (w_adv[2]) begin
            r_y <= n_ym[49:30];
        end
        if (w_adv[3]) begin
            r_e <= n_e[E_W-1:0];
        end
    end

    assign o_vld = r_vld[NSTG-1];
    assign o_ctl = r_ctl[NSTG-1];
    assign o_e   = r_e;

endmodule

// ----- sv/tvs_split.sv -----
module tvs_split (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    output logic                        o_rdy,
    input  logic [tvs_pkg::E_W-1:0]     i_e,
    input  tvs_pkg::t_ctl               i_ctl,
    output logic                        o_vld,
    input  logic                        i_rdy,
    output logic [tvs_pkg::TQ_W-1:0]    o_left,
    output logic [tvs_pkg::TQ_W-1:0]    o_right
);
    import tvs_pkg::*;

    logic            r_vld;
    logic [TQ_W-1:0] r_left;
    logic [TQ_W-1:0] r_right;

    logic            w_adv;
    logic [24:0]     n_pe;
    logic [TQ_W-1:0] n_in;
    logic [TQ_W:0]   n_out9;
    logic [TQ_W-1:0] n_out;
    logic [TQ_W-1:0] n_left;
    logic [TQ_W-1:0] n_right;

    assign w_adv = !r_vld || i_rdy;
    assign o_rdy = w_adv;

    // outside = floor(p*(2-e)) = 2p - ceil(p*e)
    always_comb begin
        n_pe   = 25'(i_ctl.p) * 25'(i_e);
        n_in   = n_pe[23:16];
        n_out9 = {i_ctl.p, 1'b0} - {1'b0, n_in} - (TQ_W+1)'(|n_pe[15:0]);
        n_out  = (n_out9 > (TQ_W+1)'(OUTSIDE_CAP)) ? OUTSIDE_CAP : n_out9[TQ_W-1:0];
        case (i_ctl.mode)
            MODE_ZERO: begin
                n_left  = '0;
                n_right = '0;
            end
            MODE_VEC: begin
                n_left  = i_ctl.right_turn ? n_out : n_in;
                n_right = i_ctl.right_turn ? n_in : n_out;
            end
            default: begin
                n_left  = i_ctl.p;
                n_right = i_ctl.p;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_adv) begin
            r_vld <= i_vld;
        end
        if (w_adv) begin
            r_left  <= n_left;
            r_right <= n_right;
        end
    end

    assign o_vld   = r_vld;
    assign o_left  = r_left;
    assign o_right = r_right;

endmodule

// ----- sv/torque_vectoring_split_core.sv -----
// Torque-vectoring split: one pedal/steering/brake sample in, one pair of
// left/right inverter torque commands (integer percent) out.
// Input stream (s_axis): tdata = pedal_raw, steer_pos (Q1.14), brake_pressed.
// Output stream (m_axis): tdata = left_torque, right_torque.
// Config channel: index 0 = vectoring enable, index 1 = deadzone level.
// Always ready; write only while no transfer is in flight.
// Throughput: one transfer per cycle unless the output stalls; seven
// register stages (base command, coefficient, steering product, log2e
// scaling, divide-by-25, exp mantissa shift, split multiply), each with
// its own valid bit.
// Reset: pipeline valids cleared, vectoring disabled, deadzone = 2.
// Output stall: each stage holds while the stage after it is full and
// stalled; empty stages still fill, so nothing is dropped or repeated and
// s_axis_tready falls only once the whole pipeline is full.
module torque_vectoring_split_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [9:0] pedal_raw, [25:10] steer_pos, [26] brake_pressed, [31:27] zero
    input  logic [tvs_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [7:0] left_torque, [15:8] right_torque
    output logic [tvs_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tvs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tvs_pkg::DZ_W-1:0]            i_cfg_data
);
    import tvs_pkg::*;

    logic            r_vec_en;
    logic [DZ_W-1:0] r_dz;

    logic            w_p_vld;
    logic            w_p_rdy;
    logic [K_W-1:0]  w_k100;
    logic [MAG_W-1:0] w_mag;
    t_ctl            w_p_ctl;

    logic            w_e_vld;
    logic            w_e_rdy;
    logic [E_W-1:0]  w_e;
    t_ctl            w_e_ctl;

    logic [TQ_W-1:0] w_left;
    logic [TQ_W-1:0] w_right;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vec_en <= 1'b0;
            r_dz     <= DEADZONE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_VEC_ENABLE: r_vec_en <= i_cfg_data[0];
                CFG_DEADZONE:   r_dz     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tvs_prep u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (i_s_axis_tvalid),
        .o_rdy    (o_s_axis_tready),
        .i_pedal  (i_s_axis_tdata[9:0]),
        .i_steer  ($signed(i_s_axis_tdata[25:10])),
        .i_brake  (i_s_axis_tdata[26]),
        .i_vec_en (r_vec_en),
        .i_dz     (r_dz),
        .o_vld    (w_p_vld),
        .i_rdy    (w_p_rdy),
        .o_k100   (w_k100),
        .o_mag    (w_mag),
        .o_ctl    (w_p_ctl)
    );

    tvs_expo u_expo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_p_vld),
        .o_rdy   (w_p_rdy),
        .i_k100  (w_k100),
        .i_mag   (w_mag),
        .i_ctl   (w_p_ctl),
        .o_vld   (w_e_vld),
        .i_rdy   (w_e_rdy),
        .o_e     (w_e),
        .o_ctl   (w_e_ctl)
    );

    tvs_split u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_e_vld),
        .o_rdy   (w_e_rdy),
        .i_e     (w_e),
        .i_ctl   (w_e_ctl),
        .o_vld   (o_m_axis_tvalid),
        .i_rdy   (i_m_axis_tready),
        .o_left  (w_left),
        .o_right (w_right)
    );

    assign o_m_axis_tdata = {w_right, w_left};

endmodule

// ----- sv/tvs_chk.sv -----
module tvs_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_m_axis_tvalid,
    input logic                                i_m_axis_tready,
    input logic [tvs_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata
);
    import tvs_pkg::*;

    logic [TQ_W-1:0] w_left;
    logic [TQ_W-1:0] w_right;

    assign w_left  = o_m_axis_tdata[7:0];
    assign w_right = o_m_axis_tdata[15:8];

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output changed during stall");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (w_left <= 8'd170) && (w_right <= 8'd170))
        else $error("torque command above base range");

    a_split_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (w_left != w_right) |->
            (w_left <= OUTSIDE_CAP) || (w_right <= OUTSIDE_CAP))
        else $error("split result without a capped side");

endmodule

bind torque_vectoring_split_core tvs_chk u_tvs_chk (.*);
